// ===== hdl/dfla_pkg.sv =====
package dfla_pkg;

  // Heap geometry.
  localparam int MAX_SLOTS = 1024;
  localparam int IDX_W     = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CNT_W     = IDX_W + 1;

  // Field widths of the stream and configuration items.
  localparam int CMD_W        = 2;
  localparam int FREE_INDEX_W = 32;
  localparam int STATUS_W     = 3;
  localparam int SLOT_INDEX_W = 10;
  localparam int ADDR_W       = 64;
  localparam int SLOT_COUNT_W = 11;
  localparam int STRIDE_W     = 32;
  localparam int PROD_W       = IDX_W + STRIDE_W;

  // Configuration port geometry.
  localparam int APB_DATA_W = 64;
  localparam int APB_ADDR_W = 6;
  localparam int REG_SEL_W  = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC  = 2'd0,
    CMD_FREE   = 2'd1,
    CMD_INIT   = 2'd2,
    CMD_UNUSED = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK           = 3'd0,
    ST_NO_HEAP      = 3'd1,
    ST_EMPTY        = 3'd2,
    ST_BAD_INDEX    = 3'd3,
    ST_ALREADY_FREE = 3'd4
  } status_t;

  typedef enum logic [REG_SEL_W-1:0] {
    REG_HEAP_READY     = 3'd0,
    REG_SLOT_COUNT     = 3'd1,
    REG_SLOT_STRIDE    = 3'd2,
    REG_CPU_BASE       = 3'd3,
    REG_GPU_BASE       = 3'd4,
    REG_SHADER_VISIBLE = 3'd5
  } reg_sel_t;

  typedef struct packed {
    logic                    heap_ready;
    logic [SLOT_COUNT_W-1:0] slot_count;
    logic [STRIDE_W-1:0]     slot_stride;
    logic [ADDR_W-1:0]       cpu_base;
    logic [ADDR_W-1:0]       gpu_base;
    logic                    shader_visible;
  } cfg_t;

endpackage

// ===== hdl/dfla_ram.sv =====
module dfla_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Single write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/dfla_regs.sv =====
module dfla_regs
  import dfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  output cfg_t                  cfg
);

  logic     wr_en;
  reg_sel_t sel;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && pready;
  assign sel    = reg_sel_t'(paddr[APB_ADDR_W-1:3]);

  // Register writes on the access phase of a write transaction.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (wr_en) begin
      unique case (sel)
        REG_HEAP_READY:     cfg.heap_ready     <= pwdata[0];
        REG_SLOT_COUNT:     cfg.slot_count     <= pwdata[SLOT_COUNT_W-1:0];
        REG_SLOT_STRIDE:    cfg.slot_stride    <= pwdata[STRIDE_W-1:0];
        REG_CPU_BASE:       cfg.cpu_base       <= pwdata[ADDR_W-1:0];
        REG_GPU_BASE:       cfg.gpu_base       <= pwdata[ADDR_W-1:0];
        REG_SHADER_VISIBLE: cfg.shader_visible <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back of the register selected by the address.
  always_comb begin
    prdata = '0;
    unique case (sel)
      REG_HEAP_READY:     prdata = APB_DATA_W'(cfg.heap_ready);
      REG_SLOT_COUNT:     prdata = APB_DATA_W'(cfg.slot_count);
      REG_SLOT_STRIDE:    prdata = APB_DATA_W'(cfg.slot_stride);
      REG_CPU_BASE:       prdata = APB_DATA_W'(cfg.cpu_base);
      REG_GPU_BASE:       prdata = APB_DATA_W'(cfg.gpu_base);
      REG_SHADER_VISIBLE: prdata = APB_DATA_W'(cfg.shader_visible);
      default:            prdata = '0;
    endcase
  end

endmodule

// ===== hdl/dfla_addr.sv =====
module dfla_addr
  import dfla_pkg::*;
(
  input  logic              clk,
  input  logic [IDX_W-1:0]  idx,
  input  cfg_t              cfg,
  output logic [ADDR_W-1:0] cpu_addr,
  output logic [ADDR_W-1:0] gpu_addr
);

  logic [PROD_W-1:0] offset;

  // First stage: slot offset, index times stride.
  always_ff @(posedge clk) begin
    offset <= PROD_W'(idx) * PROD_W'(cfg.slot_stride);
  end

  // Second stage: add the bases; the GPU address is only given for visible heaps.
  always_ff @(posedge clk) begin
    cpu_addr <= cfg.cpu_base + ADDR_W'(offset);
    if (cfg.shader_visible) begin
      gpu_addr <= cfg.gpu_base + ADDR_W'(offset);
    end else begin
      gpu_addr <= '0;
    end
  end

endmodule

// ===== hdl/descriptor_free_list_allocator.sv =====
// Descriptor slot allocator with a LIFO stack of free slot indices.
// Commands arrive on the s_ stream: tuser carries the command (allocate,
// free, init) and tdata the index to release. Each command gives exactly one
// result on the m_ stream: tuser carries the status, tdata the slot index and
// the CPU and GPU addresses of an allocated slot. Registers are written and
// read through the APB-style port; the user is to do so only while no
// command is in flight, which the block itself does not enforce.
// One command is handled at a time; s_tready is high only while idle.
// An allocate passes a stack memory read, an offset multiply and a base add;
// a free reads the free-flag memory, then pushes; an init sweeps every entry
// of the flag memory one per cycle. A new command can be taken in the cycle
// after the result has been moved into the output register.
// After reset the block clears its free-flag memory, all MAX_SLOTS (1024)
// entries, with s_tready low; configuration writes are taken meanwhile.
// A result that m_tready does not take is held in the output register; a
// following command may be accepted, and its result waits until the output
// register has been emptied.
module descriptor_free_list_allocator
  import dfla_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  // APB-style configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [APB_ADDR_W-1:0] paddr,
  input  logic [APB_DATA_W-1:0] pwdata,
  output logic [APB_DATA_W-1:0] prdata,
  output logic                  pready,
  // Command stream
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [31:0]           s_tdata,  // [31:0] free_index
  input  logic [1:0]            s_tuser,  // [1:0] cmd
  // Result stream
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [143:0]          m_tdata,  // [9:0] slot_index, [73:10] cpu_addr,
                                          // [137:74] gpu_addr, [143:138] zero
  output logic [2:0]            m_tuser   // [2:0] status
);

  typedef enum logic [6:0] {
    S_SWEEP     = 7'b0000001,
    S_IDLE      = 7'b0000010,
    S_ALLOC_RD  = 7'b0000100,
    S_ALLOC_MUL = 7'b0001000,
    S_ALLOC_ADD = 7'b0010000,
    S_FREE_RD   = 7'b0100000,
    S_DONE      = 7'b1000000
  } state_t;

  cfg_t   cfg;
  state_t state;

  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] fill_n;
  logic [IDX_W-1:0] sweep_idx;
  logic             init_reply;
  logic [IDX_W-1:0] free_idx;

  status_t           pend_status;
  logic [IDX_W-1:0]  pend_idx;
  logic [ADDR_W-1:0] pend_cpu;
  logic [ADDR_W-1:0] pend_gpu;

  logic              flag_we, flag_re, flag_wdata, flag_rdata;
  logic [IDX_W-1:0]  flag_waddr, flag_raddr;
  logic              stack_we, stack_re;
  logic [IDX_W-1:0]  stack_waddr, stack_raddr, stack_wdata, stack_rdata;
  logic [ADDR_W-1:0] cpu_addr, gpu_addr;

  cmd_t              in_cmd;
  logic [FREE_INDEX_W-1:0] in_index;
  logic              in_range;
  logic              accept;
  logic              out_free;
  logic [CNT_W-1:0]  init_n;

  dfla_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Stack of free indices.
  dfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (MAX_SLOTS)
  ) u_stack (
    .clk   (clk),
    .we    (stack_we),
    .waddr (stack_waddr),
    .wdata (stack_wdata),
    .re    (stack_re),
    .raddr (stack_raddr),
    .rdata (stack_rdata)
  );

  // One flag per slot, set while that slot lies on the stack.
  dfla_ram #(
    .WIDTH (1),
    .DEPTH (MAX_SLOTS)
  ) u_flags (
    .clk   (clk),
    .we    (flag_we),
    .waddr (flag_waddr),
    .wdata (flag_wdata),
    .re    (flag_re),
    .raddr (flag_raddr),
    .rdata (flag_rdata)
  );

  dfla_addr u_addr (
    .clk      (clk),
    .idx      (stack_rdata),
    .cfg      (cfg),
    .cpu_addr (cpu_addr),
    .gpu_addr (gpu_addr)
  );

  // Input decode.
  assign in_cmd   = cmd_t'(s_tuser);
  assign in_index = s_tdata[FREE_INDEX_W-1:0];
  assign in_range = (in_index < FREE_INDEX_W'(cfg.slot_count)) &&
                    (in_index < FREE_INDEX_W'(MAX_SLOTS));
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  // Fill size for init, saturated at the stack depth.
  always_comb begin
    if (32'(cfg.slot_count) > 32'(MAX_SLOTS)) begin
      init_n = CNT_W'(MAX_SLOTS);
    end else begin
      init_n = CNT_W'(cfg.slot_count);
    end
  end

  // Memory port control.
  always_comb begin
    flag_we     = 1'b0;
    flag_waddr  = sweep_idx;
    flag_wdata  = 1'b0;
    flag_re     = 1'b0;
    flag_raddr  = in_index[IDX_W-1:0];
    stack_we    = 1'b0;
    stack_waddr = sweep_idx;
    stack_wdata = IDX_W'(fill_n - CNT_W'(1) - CNT_W'(sweep_idx));
    stack_re    = 1'b0;
    stack_raddr = IDX_W'(depth - CNT_W'(1));
    unique case (state)
      S_SWEEP: begin
        flag_we    = 1'b1;
        flag_wdata = (CNT_W'(sweep_idx) < fill_n);
        stack_we   = 1'b1;
      end
      S_IDLE: begin
        if (accept && cfg.heap_ready) begin
          stack_re = (in_cmd == CMD_ALLOC) && (depth != '0);
          flag_re  = (in_cmd == CMD_FREE) && in_range;
        end
      end
      S_ALLOC_ADD: begin
        flag_we    = 1'b1;
        flag_waddr = stack_rdata;
        flag_wdata = 1'b0;
      end
      S_FREE_RD: begin
        if (!flag_rdata) begin
          flag_we     = 1'b1;
          flag_waddr  = free_idx;
          flag_wdata  = 1'b1;
          stack_we    = 1'b1;
          stack_waddr = depth[IDX_W-1:0];
          stack_wdata = free_idx;
        end
      end
      default: ;
    endcase
  end

  // Command sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_SWEEP;
      depth      <= '0;
      fill_n     <= '0;
      sweep_idx  <= '0;
      init_reply <= 1'b0;
    end else begin
      unique case (state)
        S_SWEEP: begin
          sweep_idx <= sweep_idx + IDX_W'(1);
          if (sweep_idx == IDX_W'(MAX_SLOTS - 1)) begin
            depth <= fill_n;
            state <= init_reply ? S_DONE : S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            unique case (in_cmd)
              CMD_ALLOC: begin
                if (cfg.heap_ready && (depth != '0)) begin
                  state <= S_ALLOC_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_FREE: begin
                if (cfg.heap_ready && in_range) begin
                  state <= S_FREE_RD;
                end else begin
                  state <= S_DONE;
                end
              end
              CMD_INIT: begin
                fill_n     <= init_n;
                sweep_idx  <= '0;
                init_reply <= 1'b1;
                state      <= S_SWEEP;
              end
              default: state <= S_DONE;
            endcase
          end
        end
        S_ALLOC_RD:  state <= S_ALLOC_MUL;
        S_ALLOC_MUL: state <= S_ALLOC_ADD;
        S_ALLOC_ADD: begin
          depth <= depth - CNT_W'(1);
          state <= S_DONE;
        end
        S_FREE_RD: begin
          if (!flag_rdata) begin
            depth <= depth + CNT_W'(1);
          end
          state <= S_DONE;
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Pending result, built up while the command is worked on.
  always_ff @(posedge clk) begin
    if (accept) begin
      free_idx    <= in_index[IDX_W-1:0];
      pend_status <= ST_OK;
      pend_idx    <= '0;
      pend_cpu    <= '0;
      pend_gpu    <= '0;
      if ((in_cmd == CMD_ALLOC) || (in_cmd == CMD_FREE)) begin
        if (!cfg.heap_ready) begin
          pend_status <= ST_NO_HEAP;
        end else if ((in_cmd == CMD_ALLOC) && (depth == '0)) begin
          pend_status <= ST_EMPTY;
        end else if ((in_cmd == CMD_FREE) && !in_range) begin
          pend_status <= ST_BAD_INDEX;
        end
      end
    end else if (state == S_ALLOC_ADD) begin
      pend_idx <= stack_rdata;
      pend_cpu <= cpu_addr;
      pend_gpu <= gpu_addr;
    end else if ((state == S_FREE_RD) && flag_rdata) begin
      pend_status <= ST_ALREADY_FREE;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if ((state == S_DONE) && out_free) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_DONE) && out_free) begin
      m_tuser <= pend_status;
      m_tdata <= {6'd0, pend_gpu, pend_cpu, SLOT_INDEX_W'(pend_idx)};
    end
  end

endmodule
